// ----- rtl/nsf_pkg.sv -----
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types and constants of the NMEA sentence framer: frame phases,
// result codes, special characters, sentence names and the result record.
// ----------------------------------------------------------------------------
package nsf_pkg;

	// default counter limits
	localparam int DEF_MAX_FIELDS = 32;
	localparam int DEF_MAX_CHARS  = 16;

	// first-field bytes that take part in the sentence type check
	localparam int NAME_LEN  = 6;
	localparam int FF_KEEP   = NAME_LEN + 1;

	// special characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// sentence names, first character in the top byte
	localparam logic [8*NAME_LEN-1:0] NAME_RMC = "$GPRMC";
	localparam logic [8*NAME_LEN-1:0] NAME_GGA = "$GPGGA";

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_BODY = 2'd1,
		PH_CSUM = 2'd2,
		PH_PROC = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		RES_PEND  = 3'd0,
		RES_RMC   = 3'd1,
		RES_GGA   = 3'd2,
		RES_OTHER = 3'd3,
		RES_OVF   = 3'd4
	} res_code_t;

	// one result request
	typedef struct packed {
		res_code_t   code;
		logic        bad;
		phase_t      phase;
		logic [7:0]  csum;
	} res_t;

endpackage

// ----- rtl/nsf_frame_core.sv -----
// ----------------------------------------------------------------------------
// nsf_frame_core
// Frame state of the sentence framer: phase, field and character counters,
// running checksum, received checksum digits and the first-field store.
// Gives the result of the byte on the input as it is accepted.
// ----------------------------------------------------------------------------
module nsf_frame_core import nsf_pkg::*; #(
	parameter int MAX_FIELDS = DEF_MAX_FIELDS,
	parameter int MAX_CHARS  = DEF_MAX_CHARS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	output res_t        res
);

	localparam int FC_W = $clog2(MAX_FIELDS);
	localparam int CP_W = $clog2(MAX_CHARS);

	phase_t            ph_q, ph_d;
	logic [FC_W-1:0]   fc_q, fc_d;
	logic [CP_W-1:0]   cp_q, cp_d;
	logic [7:0]        xs_q, xs_d;
	logic [7:0]        cs_q [2];
	logic [7:0]        cs_d [2];
	logic [7:0]        ff_q [FF_KEEP];
	logic [7:0]        ff_d [FF_KEEP];
	logic              err_q, err_d;
	logic              limit;
	res_code_t         code;

	// ascii hex digit to nibble, anything else reads as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			v = 4'(c[2:0] + 3'd1) + 4'd8;
		return v;
	endfunction

	// first field equals a name, with the byte after it empty
	function automatic logic name_match(input logic [7:0] ff [FF_KEEP],
	                                    input logic [8*NAME_LEN-1:0] name);
		logic m;
		m = (ff[NAME_LEN] == 8'd0);
		for (int i = 0; i < NAME_LEN; i++)
			if (ff[i] != name[8*(NAME_LEN-i)-1 -: 8]) m = 1'b0;
		return m;
	endfunction

	assign limit = (fc_q == FC_W'(MAX_FIELDS - 1)) || (cp_q == CP_W'(MAX_CHARS - 1));

	// next phase
	always_comb begin
		ph_d = ph_q;
		if (limit) begin
			ph_d = PH_HUNT;
		end else begin
			case (ph_q)
				PH_HUNT: if (rx_byte == CH_DOLLAR) ph_d = PH_BODY;
				PH_BODY: if (rx_byte == CH_STAR) ph_d = PH_CSUM;
				PH_CSUM: if (rx_byte == CH_CR) ph_d = PH_PROC;
				PH_PROC: ph_d = PH_HUNT;
				default: ph_d = PH_HUNT;
			endcase
		end
	end

	// counters, checksum, stores and result code
	always_comb begin
		logic       keep;
		logic       restart;
		logic [7:0] rx_sum;
		keep    = 1'b0;
		restart = 1'b0;
		rx_sum  = {hex_value(cs_q[0]), hex_value(cs_q[1])};
		fc_d    = fc_q;
		cp_d    = cp_q;
		xs_d    = xs_q;
		cs_d    = cs_q;
		ff_d    = ff_q;
		err_d   = err_q;
		code    = RES_PEND;
		if (limit) begin
			code    = RES_OVF;
			restart = 1'b1;
		end else begin
			case (ph_q)
				PH_HUNT: begin
					if (rx_byte == CH_DOLLAR) begin
						keep = 1'b1;
						xs_d = 8'd0;
					end
				end
				PH_BODY: begin
					if (rx_byte == CH_COMMA) begin
						fc_d = fc_q + FC_W'(1);
						cp_d = '0;
						xs_d = xs_q ^ rx_byte;
					end else if (rx_byte == CH_STAR) begin
						fc_d = fc_q + FC_W'(1);
						cp_d = '0;
					end else begin
						xs_d = xs_q ^ rx_byte;
						keep = 1'b1;
					end
				end
				PH_CSUM: begin
					if (cp_q == CP_W'(0)) begin
						cs_d[0] = rx_byte;
						cp_d    = cp_q + CP_W'(1);
					end else if (cp_q == CP_W'(1)) begin
						cs_d[1] = rx_byte;
						cp_d    = cp_q + CP_W'(1);
					end
				end
				PH_PROC: begin
					if (rx_sum != xs_q) begin
						err_d = 1'b1;
					end else begin
						err_d = 1'b0;
						if (name_match(ff_q, NAME_RMC)) code = RES_RMC;
						else if (name_match(ff_q, NAME_GGA)) code = RES_GGA;
						else code = RES_OTHER;
					end
					restart = 1'b1;
				end
				default: restart = 1'b1;
			endcase
		end
		// keep a first-field character
		if (keep) begin
			if (fc_q == '0) begin
				for (int i = 0; i < FF_KEEP; i++)
					if (cp_q == CP_W'(i)) ff_d[i] = rx_byte;
			end
			cp_d = cp_q + CP_W'(1);
		end
		// restart clears everything but the error flag
		if (restart) begin
			fc_d = '0;
			cp_d = '0;
			xs_d = 8'd0;
			for (int i = 0; i < 2; i++) cs_d[i] = 8'd0;
			for (int i = 0; i < FF_KEEP; i++) ff_d[i] = 8'd0;
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HUNT;
			fc_q  <= '0;
			cp_q  <= '0;
			xs_q  <= 8'd0;
			err_q <= 1'b0;
			for (int i = 0; i < 2; i++) cs_q[i] <= 8'd0;
			for (int i = 0; i < FF_KEEP; i++) ff_q[i] <= 8'd0;
		end else if (accept) begin
			ph_q  <= ph_d;
			fc_q  <= fc_d;
			cp_q  <= cp_d;
			xs_q  <= xs_d;
			err_q <= err_d;
			cs_q  <= cs_d;
			ff_q  <= ff_d;
		end
	end

	// result of the byte being accepted
	assign res.code  = code;
	assign res.bad   = err_d;
	assign res.phase = ph_d;
	assign res.csum  = xs_d;

endmodule

// ----- rtl/nsf_out_reg.sv -----
// ----------------------------------------------------------------------------
// nsf_out_reg
// Result register with valid and stall: takes a new result whenever the held
// one is gone or leaves in the same cycle.
// ----------------------------------------------------------------------------
module nsf_out_reg import nsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  accept,
	input  res_t  res_in,
	output logic  out_valid,
	input  logic  out_stall,
	output res_t  res_out
);

	logic valid_q;
	res_t data_q;

	// hold off the source only while a result waits on a stalled sink
	assign in_stall = valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = data_q;

endmodule

// ----- rtl/nmea_sentence_framer.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// Frames NMEA sentences from received bytes, checks the XOR checksum and
// reports the sentence type, a held checksum error flag and counter overflow.
// ----------------------------------------------------------------------------
// the result of a byte is registered as the byte is taken and valid in the cycle after
// throughput: one byte per cycle while no held result is stalled, set by the single result register
// in_stall is high only while a result is held and out_stall is high
// reset (arst_n low): frame in hunt, counters, checksum, stores and error flag
// cleared, no result pending
module nmea_sentence_framer import nsf_pkg::*; #(
	parameter int MAX_FIELDS = DEF_MAX_FIELDS,
	parameter int MAX_CHARS  = DEF_MAX_CHARS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_code,
	output logic        bad_checksum,
	output logic [1:0]  frame_phase,
	output logic [7:0]  running_checksum
);

	logic accept;
	res_t res_next;
	res_t res_held;

	// frame state and next result
	nsf_frame_core #(
		.MAX_FIELDS (MAX_FIELDS),
		.MAX_CHARS  (MAX_CHARS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.res     (res_next)
	);

	// result register
	nsf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.accept    (accept),
		.res_in    (res_next),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_held)
	);

	// result fields
	assign result_code      = res_held.code;
	assign bad_checksum     = res_held.bad;
	assign frame_phase      = res_held.phase;
	assign running_checksum = res_held.csum;

endmodule
